// ----- rtl/coses_pkg.sv -----
package coses_pkg;

    // Field and state widths
    localparam int ID_BITS       = 16;
    localparam int FRACTION_BITS = 16;
    localparam int TIME_W        = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int ELAPSED_W     = 16;
    localparam int REPLY_ID_W    = 16;
    localparam int REQ_ID_W      = 16;
    localparam int WT_W          = 40;
    localparam int EST_W         = TIME_W + 1;

    // Id compare width covers both the reply field and the counter
    localparam int ID_CMP_W = (ID_BITS > REPLY_ID_W) ? ID_BITS : REPLY_ID_W;

    // Mean is signed Q32.F
    localparam int MEAN_W = TIME_W + FRACTION_BITS;

    // Weight numerator is 100 in QF; 100 needs 7 bits
    localparam int WSCALE_W = 7;
    localparam int WGT_W    = FRACTION_BITS + WSCALE_W;

    // Offset in half-ms (2d - p) needs TIME_W + 2 bits, scaled by 2^(F-1)
    localparam int OFF_W  = TIME_W + 2 + FRACTION_BITS - 1;
    localparam int MAG_W  = OFF_W + 1;
    localparam int UPD_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + WGT_W;
    localparam int DEN_W  = WT_W + 1;

    // Serial step counters
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int MCNT_W = $clog2(WGT_W + 1);

    localparam logic [WGT_W-1:0]  WEIGHT_NUM  = WGT_W'(100) << FRACTION_BITS;
    localparam logic [WT_W-1:0]   WEIGHT_MAX  = '1;
    localparam logic [MEAN_W-1:0] TRUNC_BIAS  = (MEAN_W'(1) << FRACTION_BITS) - MEAN_W'(1);
    localparam logic [TIME_W-1:0] EST_BIAS    = TIME_W'(4);
    localparam logic [CFG_W-1:0]  PERIOD_RST  = CFG_W'(1000);
    localparam logic [CFG_W-1:0]  MAX_PING_RST = CFG_W'(200);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD   = 1'b0,
        CFG_MAX_PING = 1'b1
    } t_cfg_idx;

    // Control sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_ADD,
        S_TICK_CHK,
        S_REPLY,
        S_OFF,
        S_DIFF,
        S_WWAIT,
        S_MULST,
        S_MWAIT,
        S_QWAIT,
        S_UPD,
        S_AVG,
        S_EMIT
    } t_state;

    // Serial divider request
    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  count;
        logic [PROD_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    // Serial multiplier request
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [WGT_W-1:0] weight;
    } t_mul_req;

endpackage

// ----- rtl/clock_offset_sync_estimator_unit.sv -----
// A tick word passes through S_TICK_ADD, S_TICK_CHK, S_AVG and S_EMIT before its result is
// registered; a reply with a wrong id or an out-of-range round trip passes through S_REPLY, S_AVG and S_EMIT.
// An accepted reply runs a 23-step serial weight division,
// a 23-step serial multiply and a 73-step serial division of the mean update.
// Throughput: one word at a time, taken the cycle after the previous result is registered.
// Reset (synchronous, active low) clears the architectural state and output valid; period 1000 ms, max ping 200 ms.
module clock_offset_sync_estimator_unit
    import coses_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // input words
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_mode,
    input  logic [ELAPSED_W-1:0]     i_elapsed_ms,
    input  logic [TIME_W-1:0]        i_local_time_ms,
    input  logic [REPLY_ID_W-1:0]    i_reply_id,
    input  logic [TIME_W-1:0]        i_server_time_ms,
    // result words
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_request_issued,
    output logic [REQ_ID_W-1:0]      o_request_id,
    output logic                     o_reply_accepted,
    output logic signed [TIME_W-1:0] o_round_trip_ms,
    output logic                     o_synced,
    output logic signed [TIME_W-1:0] o_offset_average_ms,
    output logic signed [EST_W-1:0]  o_server_time_estimate
);

    t_state r_state, n_state;

    // Configuration and architectural state
    logic [CFG_W-1:0]         r_period;
    logic [CFG_W-1:0]         r_max_ping;
    logic [TIME_W-1:0]        r_acc;
    logic [ID_BITS-1:0]       r_req_num;
    logic [TIME_W-1:0]        r_send;
    logic [TIME_W-1:0]        r_ping;
    logic signed [MEAN_W-1:0] r_mean;
    logic [WT_W-1:0]          r_wt;
    logic                     r_sync;
    logic                     r_issued;
    logic                     r_accepted;
    logic                     r_out_valid;

    // Captured word and work registers
    logic [ELAPSED_W-1:0]     r_elapsed;
    logic [TIME_W-1:0]        r_local;
    logic [REPLY_ID_W-1:0]    r_rid;
    logic [TIME_W-1:0]        r_server;
    logic [TIME_W-1:0]        r_dlt;
    logic signed [OFF_W-1:0]  r_off;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [WGT_W-1:0]         r_w;
    logic [DEN_W-1:0]         r_den;
    logic [MAG_W-1:0]         r_q;
    logic signed [TIME_W-1:0] r_avg;

    // Result register
    logic                     r_out_issued;
    logic [REQ_ID_W-1:0]      r_out_req_id;
    logic                     r_out_accepted;
    logic [TIME_W-1:0]        r_out_ping;
    logic                     r_out_synced;
    logic [TIME_W-1:0]        r_out_avg;
    logic [EST_W-1:0]         r_out_est;

    // Combinational datapath
    logic                     in_take;
    logic                     out_free;
    logic [TIME_W:0]          acc_sum;
    logic [TIME_W-1:0]        acc_sat;
    logic [TIME_W-1:0]        period_ext;
    logic                     issue;
    logic                     id_match;
    logic [TIME_W-1:0]        ping;
    logic                     ping_ok;
    logic [TIME_W-1:0]        dlt;
    logic signed [TIME_W+1:0] half_off;
    logic signed [MAG_W-1:0]  diff;
    logic [WGT_W-1:0]         wq;
    logic [WGT_W-1:0]         w_fix;
    logic signed [UPD_W-1:0]  mean_ext;
    logic signed [UPD_W-1:0]  q_ext;
    logic signed [UPD_W-1:0]  mean_sum;
    logic                     mean_ovf;
    logic [MEAN_W-1:0]        mean_sat;
    logic [MEAN_W-1:0]        mean_bias;
    logic [MEAN_W-1:0]        mean_rnd;
    logic [TIME_W-1:0]        est;

    t_div_req                 div_req;
    t_mul_req                 mul_req;
    logic                     div_done;
    logic                     mul_done;
    logic [PROD_W-1:0]        div_quo;
    logic [PROD_W-1:0]        mul_prod;

    coses_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    coses_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    // Handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Tick: saturating accumulate, then period check
    assign acc_sum    = {1'b0, r_acc} + (TIME_W + 1)'(r_elapsed);
    assign acc_sat    = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
    assign period_ext = TIME_W'(r_period);
    assign issue      = r_acc >= period_ext;

    // Reply: id match, round trip and server delta
    assign id_match = ID_CMP_W'(r_rid) == ID_CMP_W'(r_req_num);
    assign ping     = r_local - r_send;
    assign ping_ok  = (ping != '0) && (ping <= TIME_W'(r_max_ping));
    assign dlt      = r_server - r_send;

    // Offset in half-ms: 2d - p
    assign half_off = $signed({r_dlt[TIME_W-1], r_dlt, 1'b0}) - $signed({2'b00, r_ping});

    // Offset minus mean
    assign diff = $signed({{(MAG_W-OFF_W){r_off[OFF_W-1]}}, r_off})
                - $signed({{(MAG_W-MEAN_W){r_mean[MEAN_W-1]}}, r_mean});

    // Weight, never below one LSB
    assign wq    = div_quo[WGT_W-1:0];
    assign w_fix = (wq == '0) ? WGT_W'(1) : wq;

    // Mean update with saturation to the Q32.F range
    assign mean_ext = $signed({{(UPD_W-MEAN_W){r_mean[MEAN_W-1]}}, r_mean});
    assign q_ext    = $signed({1'b0, r_q});
    assign mean_sum = r_neg ? (mean_ext - q_ext) : (mean_ext + q_ext);
    assign mean_ovf = (mean_sum[UPD_W-1:MEAN_W-1] != '0) && (mean_sum[UPD_W-1:MEAN_W-1] != '1);
    always_comb begin
        if (!mean_ovf) begin
            mean_sat = mean_sum[MEAN_W-1:0];
        end else if (mean_sum[UPD_W-1]) begin
            mean_sat = {1'b1, {(MEAN_W-1){1'b0}}};
        end else begin
            mean_sat = {1'b0, {(MEAN_W-1){1'b1}}};
        end
    end

    // Mean truncated toward zero to whole ms
    assign mean_bias = r_mean[MEAN_W-1] ? TRUNC_BIAS : '0;
    assign mean_rnd  = r_mean + mean_bias;

    assign est = r_local + r_avg + EST_BIAS;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit requests
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.count    = CNT_W'(PROD_W);
        div_req.dividend = mul_prod;
        div_req.divisor  = r_den;
        mul_req.start    = 1'b0;
        mul_req.mag      = r_mag;
        mul_req.weight   = r_w;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = i_mode ? S_REPLY : S_TICK_ADD;
                end
            end
            S_TICK_ADD: n_state = S_TICK_CHK;
            S_TICK_CHK: n_state = S_AVG;
            S_REPLY: begin
                n_state = (id_match && ping_ok) ? S_OFF : S_AVG;
            end
            S_OFF: begin
                div_req.start    = 1'b1;
                div_req.count    = CNT_W'(WGT_W);
                div_req.dividend = {WEIGHT_NUM, {(PROD_W-WGT_W){1'b0}}};
                div_req.divisor  = DEN_W'(r_ping);
                n_state          = S_DIFF;
            end
            S_DIFF: n_state = S_WWAIT;
            S_WWAIT: begin
                if (div_done) begin
                    n_state = S_MULST;
                end
            end
            S_MULST: begin
                mul_req.start = 1'b1;
                n_state       = S_MWAIT;
            end
            S_MWAIT: begin
                if (mul_done) begin
                    div_req.start = 1'b1;
                    n_state       = S_QWAIT;
                end
            end
            S_QWAIT: begin
                if (div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_AVG;
            S_AVG: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RST;
            r_max_ping  <= MAX_PING_RST;
            r_acc       <= '0;
            r_req_num   <= '0;
            r_send      <= '0;
            r_ping      <= '0;
            r_mean      <= '0;
            r_wt        <= '0;
            r_sync      <= 1'b0;
            r_issued    <= 1'b0;
            r_accepted  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PERIOD:   r_period   <= i_cfg_data;
                    CFG_MAX_PING: r_max_ping <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_issued   <= 1'b0;
                r_accepted <= 1'b0;
            end
            case (r_state)
                S_TICK_ADD: r_acc <= acc_sat;
                S_TICK_CHK: begin
                    if (issue) begin
                        r_send    <= r_local;
                        r_req_num <= r_req_num + ID_BITS'(1);
                        r_acc     <= r_acc - period_ext;
                        r_issued  <= 1'b1;
                    end
                end
                S_REPLY: begin
                    if (id_match) begin
                        r_ping <= ping;
                    end
                end
                S_UPD: begin
                    r_mean     <= $signed(mean_sat);
                    r_wt       <= r_den[WT_W] ? WEIGHT_MAX : r_den[WT_W-1:0];
                    r_sync     <= 1'b1;
                    r_accepted <= 1'b1;
                end
                default: ;
            endcase
            // result register
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured word and work registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_elapsed <= i_elapsed_ms;
            r_local   <= i_local_time_ms;
            r_rid     <= i_reply_id;
            r_server  <= i_server_time_ms;
        end
        case (r_state)
            S_REPLY: r_dlt <= dlt;
            S_OFF:   r_off <= {half_off, {(FRACTION_BITS-1){1'b0}}};
            S_DIFF: begin
                r_neg <= diff[MAG_W-1];
                r_mag <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
            end
            S_WWAIT: begin
                if (div_done) begin
                    r_w <= w_fix;
                end
            end
            S_MULST: r_den <= DEN_W'(r_wt) + DEN_W'(r_w);
            S_QWAIT: begin
                if (div_done) begin
                    r_q <= div_quo[MAG_W-1:0];
                end
            end
            S_AVG:   r_avg <= $signed(mean_rnd[MEAN_W-1:FRACTION_BITS]);
            S_EMIT: begin
                if (out_free) begin
                    r_out_issued   <= r_issued;
                    r_out_req_id   <= REQ_ID_W'(r_req_num);
                    r_out_accepted <= r_accepted;
                    r_out_ping     <= r_ping;
                    r_out_synced   <= r_sync;
                    r_out_avg      <= r_avg;
                    r_out_est      <= r_sync ? {1'b0, est} : '1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid            = r_out_valid;
    assign o_request_issued       = r_out_issued;
    assign o_request_id           = r_out_req_id;
    assign o_reply_accepted       = r_out_accepted;
    assign o_round_trip_ms        = $signed(r_out_ping);
    assign o_synced               = r_out_synced;
    assign o_offset_average_ms    = $signed(r_out_avg);
    assign o_server_time_estimate = $signed(r_out_est);

    // An accepted reply word always reports synced
    a_accept_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reply_accepted |-> o_synced)
        else $error("accepted reply without sync");

    // A word is either a tick or a reply
    a_issue_accept_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_request_issued && o_reply_accepted))
        else $error("request and accept in one word");

    // Total weight never decreases
    a_weight_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_wt >= $past(r_wt))
        else $error("total weight decreased");

    // Sync flag is sticky
    a_sync_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_sync) |-> r_sync)
        else $error("sync flag dropped");

    // Once synced the weight is at least one LSB
    a_sync_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sync |-> r_wt != '0)
        else $error("synced with zero weight");

endmodule

// ----- rtl/coses_mul.sv -----
module coses_mul
    import coses_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic [PROD_W-1:0] r_p;
    logic [MAG_W-1:0]  r_mag;
    logic [MCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [MAG_W:0]    part_sum;

    // One multiplier bit per cycle, LSB first; product shifts down
    assign part_sum = {1'b0, r_p[PROD_W-1:WGT_W]} + (r_p[0] ? {1'b0, r_mag} : '0);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == MCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_p   <= {{MAG_W{1'b0}}, i_req.weight};
            r_mag <= i_req.mag;
            r_cnt <= MCNT_W'(WGT_W);
        end else if (r_busy) begin
            r_p   <= {part_sum, r_p[WGT_W-1:1]};
            r_cnt <= r_cnt - MCNT_W'(1);
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

// ----- rtl/coses_div.sv -----
module coses_div
    import coses_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    logic [PROD_W-1:0] r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              fits;

    // Restoring step: one dividend bit in, one quotient bit out
    assign trial     = {r_rem, r_q[PROD_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign fits      = trial >= {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: dividend and quotient share one shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_cnt <= i_req.count;
        end else if (r_busy) begin
            r_q   <= {r_q[PROD_W-2:0], fits};
            r_rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
